>>> rtl/core/gcmd_pkg.sv
// Shared types, gamma table builder and queue item for the mip downsampler.
package gcmd_pkg;

	typedef logic [15:0] lin_tab_t [256];

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// one averaged square waiting for conversion back to codes
	typedef struct packed {
		logic [15:0] avg_red;
		logic [15:0] avg_green;
		logic [15:0] avg_blue;
		logic [7:0]  avg_alpha;
		logic        row_end;
		logic        image_end;
	} gcmd_item_t;

	function automatic longint unsigned isqrt64(input longint unsigned n_in);
		longint unsigned n;
		longint unsigned r;
		longint unsigned b;
		n = n_in;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// linear value of each code, 16-bit fraction of 65535
	function automatic lin_tab_t build_lin(input int unsigned gamma_milli);
		lin_tab_t        t;
		longint unsigned x;
		longint unsigned acc;
		int unsigned     rem;
		int unsigned     whole;
		t[0] = 16'd0;
		for (int v = 1; v < 256; v++) begin
			x     = (longint'(v) << 30) / 255;
			acc   = 64'd1 << 30;
			rem   = gamma_milli % 1000;
			whole = gamma_milli / 1000;
			for (int k = 0; k < 8; k++) begin
				if (k < whole) acc = (acc * x) >> 30;
			end
			for (int i = 0; i < 24; i++) begin
				x   = isqrt64(x << 30);
				rem = rem * 2;
				if (rem >= 1000) begin
					rem = rem - 1000;
					acc = (acc * x) >> 30;
				end
			end
			t[v] = 16'((acc * 65535 + (64'd1 << 29)) >> 30);
		end
		return t;
	endfunction

endpackage

>>> rtl/core/gcmd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module gcmd_ram #(
	parameter int unsigned WIDTH = 60,
	parameter int unsigned DEPTH = 2048,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/core/gcmd_front.sv
// Front end: pixel accept, position tracking, pair sums and square totals.
module gcmd_front
	import gcmd_pkg::*;
#(
	parameter int unsigned MAX_WIDTH   = 4096,
	parameter int unsigned MAX_HEIGHT  = 4096,
	parameter int unsigned GAMMA_MILLI = 2200,
	parameter int unsigned WW  = $clog2(MAX_WIDTH + 1),
	parameter int unsigned HW  = $clog2(MAX_HEIGHT + 1),
	parameter int unsigned NWW = $clog2(MAX_WIDTH / 2 + 1),
	parameter int unsigned NHW = $clog2(MAX_HEIGHT / 2 + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            restart,
	input  logic [WW-1:0]   w,
	input  logic [HW-1:0]   h,
	input  logic [NWW-1:0]  nw,
	input  logic [NHW-1:0]  nh,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      in_red,
	input  logic [7:0]      in_green,
	input  logic [7:0]      in_blue,
	input  logic [7:0]      in_alpha,
	input  logic [QCNT_W-1:0] q_count,
	output logic            push,
	output gcmd_item_t      push_item
);

	localparam lin_tab_t    LIN        = build_lin(GAMMA_MILLI);
	localparam int unsigned PAIR_SLOTS = (MAX_WIDTH + 1) / 2;
	localparam int unsigned AW         = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;

	logic [WW-1:0] x_q;
	logic [HW-1:0] y_q;
	logic [15:0]   hold_r_q, hold_g_q, hold_b_q;
	logic [7:0]    hold_a_q;

	logic          accept, wide, tall, work;
	logic [15:0]   cur_r, cur_g, cur_b;
	logic [NWW-1:0] ox;
	logic [NHW-1:0] oy;
	logic [16:0]   pr, pg, pb;
	logic [8:0]    pa;
	logic          even_col, even_row;
	logic [WW:0]   x_inc;
	logic [HW:0]   y_inc;

	logic          v_s1, tall_s1, re_s1, ie_s1;
	logic [59:0]   pair_s1;
	logic [59:0]   ram_rd;

	assign in_stall = ({1'b0, q_count} + (QCNT_W+1)'(v_s1)) >= (QCNT_W+1)'(QUEUE_DEPTH);
	assign accept   = in_valid && !in_stall;

	assign cur_r = LIN[in_red];
	assign cur_g = LIN[in_green];
	assign cur_b = LIN[in_blue];

	assign wide = w > WW'(1);
	assign tall = h > HW'(1);
	assign ox   = wide ? NWW'(x_q >> 1) : '0;
	assign oy   = tall ? NHW'(y_q >> 1) : '0;
	assign work = !(!wide && !tall) && (!wide || ox < nw) && (!tall || oy < nh);
	assign even_col = wide && !x_q[0];
	assign even_row = tall && !y_q[0];

	assign pr = wide ? 17'(hold_r_q) + 17'(cur_r) : {cur_r, 1'b0};
	assign pg = wide ? 17'(hold_g_q) + 17'(cur_g) : {cur_g, 1'b0};
	assign pb = wide ? 17'(hold_b_q) + 17'(cur_b) : {cur_b, 1'b0};
	assign pa = wide ? 9'(hold_a_q) + 9'(in_alpha) : {in_alpha, 1'b0};

	assign x_inc = {1'b0, x_q} + (WW+1)'(1);
	assign y_inc = {1'b0, y_q} + (HW+1)'(1);

	gcmd_ram #(.WIDTH(60), .DEPTH(PAIR_SLOTS), .AW(AW)) u_pair_ram (
		.clk     (clk),
		.wr_en   (accept && work && !even_col && even_row),
		.wr_addr (AW'(ox)),
		.wr_data ({pr, pg, pb, pa}),
		.rd_en   (accept),
		.rd_addr (AW'(ox)),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			y_q  <= '0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && work && !even_col && !even_row;
			if (restart) begin
				x_q <= '0;
				y_q <= '0;
			end else if (accept) begin
				if (x_inc >= (WW+1)'(w)) begin
					x_q <= '0;
					if (y_inc >= (HW+1)'(h)) y_q <= '0;
					else y_q <= HW'(y_inc);
				end else begin
					x_q <= WW'(x_inc);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && work && even_col) begin
			hold_r_q <= cur_r;
			hold_g_q <= cur_g;
			hold_b_q <= cur_b;
			hold_a_q <= in_alpha;
		end
		if (accept) begin
			pair_s1 <= {pr, pg, pb, pa};
			tall_s1 <= tall;
			re_s1   <= ox == nw - NWW'(1);
			ie_s1   <= (ox == nw - NWW'(1)) && (oy == nh - NHW'(1));
		end
	end

	// square totals: even-row pair from RAM, or the pair doubled for height one
	logic [17:0] tr, tg, tb;
	logic [9:0]  ta;
	always_comb begin
		if (tall_s1) begin
			tr = 18'(pair_s1[59:43]) + 18'(ram_rd[59:43]);
			tg = 18'(pair_s1[42:26]) + 18'(ram_rd[42:26]);
			tb = 18'(pair_s1[25:9])  + 18'(ram_rd[25:9]);
			ta = 10'(pair_s1[8:0])   + 10'(ram_rd[8:0]);
		end else begin
			tr = {pair_s1[59:43], 1'b0};
			tg = {pair_s1[42:26], 1'b0};
			tb = {pair_s1[25:9], 1'b0};
			ta = {pair_s1[8:0], 1'b0};
		end
	end

	assign push                = v_s1;
	assign push_item.avg_red   = tr[17:2];
	assign push_item.avg_green = tg[17:2];
	assign push_item.avg_blue  = tb[17:2];
	assign push_item.avg_alpha = ta[9:2];
	assign push_item.row_end   = re_s1;
	assign push_item.image_end = ie_s1;

endmodule

>>> rtl/core/gcmd_queue.sv
// Short FIFO between the front end and the code conversion back end.
module gcmd_queue
	import gcmd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gcmd_item_t        push_item,
	input  logic              pop,
	output logic              not_empty,
	output gcmd_item_t        head,
	output logic [QCNT_W-1:0] count
);

	gcmd_item_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

>>> rtl/core/gcmd_back.sv
// Back end: eight-step binary search of the gamma table per color channel.
module gcmd_back
	import gcmd_pkg::*;
#(
	parameter int unsigned GAMMA_MILLI = 2200
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       not_empty,
	input  gcmd_item_t head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic [7:0] out_alpha,
	output logic       row_end,
	output logic       image_end
);

	localparam lin_tab_t LIN = build_lin(GAMMA_MILLI);

	logic        en;
	logic        v_s  [8];
	logic [7:0]  n_s  [8][3];
	logic [15:0] avg_s[7][3];
	logic [7:0]  a_s  [8];
	logic        re_s [8];
	logic        ie_s [8];

	assign en  = !(v_s[7] && out_stall);
	assign pop = en && not_empty;

	for (genvar k = 0; k < 8; k++) begin : g_step
		localparam logic [7:0] BIT = 8'(1 << (7 - k));
		logic [7:0]  n_in  [3];
		logic [15:0] avg_in[3];
		logic [7:0]  n_nx  [3];
		logic        v_in, re_in, ie_in;
		logic [7:0]  a_in;

		if (k == 0) begin : g_head
			assign v_in      = not_empty;
			assign n_in[0]   = '0;
			assign n_in[1]   = '0;
			assign n_in[2]   = '0;
			assign avg_in[0] = head.avg_red;
			assign avg_in[1] = head.avg_green;
			assign avg_in[2] = head.avg_blue;
			assign a_in      = head.avg_alpha;
			assign re_in     = head.row_end;
			assign ie_in     = head.image_end;
		end else begin : g_prev
			assign v_in   = v_s[k-1];
			assign n_in   = n_s[k-1];
			assign avg_in = avg_s[k-1];
			assign a_in   = a_s[k-1];
			assign re_in  = re_s[k-1];
			assign ie_in  = ie_s[k-1];
		end

		for (genvar c = 0; c < 3; c++) begin : g_ch
			assign n_nx[c] = (LIN[n_in[c] | BIT] <= avg_in[c]) ? (n_in[c] | BIT) : n_in[c];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k]  <= n_nx;
				a_s[k]  <= a_in;
				re_s[k] <= re_in;
				ie_s[k] <= ie_in;
			end
		end

		if (k < 7) begin : g_avg
			always_ff @(posedge clk) begin
				if (en) avg_s[k] <= avg_in;
			end
		end
	end

	assign out_valid = v_s[7];
	assign out_red   = n_s[7][0];
	assign out_green = n_s[7][1];
	assign out_blue  = n_s[7][2];
	assign out_alpha = a_s[7];
	assign row_end   = re_s[7];
	assign image_end = ie_s[7];

endmodule

>>> rtl/core/gamma_correct_mip_downsample_unit.sv
// Top level of the gamma-correct 2x2 box-filter mip downsampler.
//
//  channel  | handshake               | beat payload
//  ---------+-------------------------+-------------------------------------------
//  pixel in | in_valid / in_stall     | in_red, in_green, in_blue, in_alpha
//  mip out  | out_valid / out_stall   | out_red..out_alpha, row_end, image_end,
//           |                         | dest_width, dest_height
//  config   | APB psel/penable/pwrite | 0x0 source_width, 0x4 source_height
//
// One pixel beat per clock sustained while in_stall stays low. An output beat
// follows the beat of the bottom-right pixel of its square through the pair RAM
// read register, the queue and the eight steps of the gamma table binary search.
// Reset clears counters, pipeline valids and queue; the pair RAM holds no reset.
// out_stall on a valid output beat freezes the search pipeline; the 4-entry queue
// then fills and in_stall rises once it cannot take the results still in flight.
// A register write restarts the image at the top-left pixel.
module gamma_correct_mip_downsample_unit
	import gcmd_pkg::*;
#(
	parameter int unsigned MAX_WIDTH   = 4096,
	parameter int unsigned MAX_HEIGHT  = 4096,
	parameter int unsigned GAMMA_MILLI = 2200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	input  logic [7:0]  in_alpha,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	output logic        row_end,
	output logic        image_end,
	output logic [11:0] dest_width,
	output logic [11:0] dest_height
);

	localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned NWW = $clog2(MAX_WIDTH / 2 + 1);
	localparam int unsigned NHW = $clog2(MAX_HEIGHT / 2 + 1);

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	logic [12:0] src_width_q, src_height_q;
	logic        cfg_wr;

	// register index is paddr[2]; low address bits are ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(src_height_q) : 32'(src_width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 13'd1;
			src_height_q <= 13'd1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIDTH:  src_width_q  <= pwdata[12:0];
				REG_HEIGHT: src_height_q <= pwdata[12:0];
				default:    src_width_q  <= src_width_q;
			endcase
		end
	end

	// effective sizes: zero acts as one, above the maximum acts as the maximum
	logic [31:0]    w32, h32;
	logic [WW-1:0]  w;
	logic [HW-1:0]  h;
	logic [NWW-1:0] nw;
	logic [NHW-1:0] nh;

	always_comb begin
		w32 = 32'(src_width_q);
		h32 = 32'(src_height_q);
		if (w32 == 32'd0) w32 = 32'd1;
		else if (w32 > MAX_WIDTH) w32 = MAX_WIDTH;
		if (h32 == 32'd0) h32 = 32'd1;
		else if (h32 > MAX_HEIGHT) h32 = MAX_HEIGHT;
		w  = WW'(w32);
		h  = HW'(h32);
		nw = (w32 > 32'd1) ? NWW'(w32 >> 1) : NWW'(1);
		nh = (h32 > 32'd1) ? NHW'(h32 >> 1) : NHW'(1);
	end

	// the user keeps sizes static while beats are pending, unchecked by the block, so they go out directly
	assign dest_width  = 12'(nw);
	assign dest_height = 12'(nh);

	logic              push, pop, not_empty;
	gcmd_item_t        push_item, head;
	logic [QCNT_W-1:0] q_count;

	gcmd_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .GAMMA_MILLI(GAMMA_MILLI),
		.WW(WW), .HW(HW), .NWW(NWW), .NHW(NHW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_wr),
		.w         (w),
		.h         (h),
		.nw        (nw),
		.nh        (nh),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.in_alpha  (in_alpha),
		.q_count   (q_count),
		.push      (push),
		.push_item (push_item)
	);

	gcmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head),
		.count     (q_count)
	);

	gcmd_back #(.GAMMA_MILLI(GAMMA_MILLI)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.out_alpha (out_alpha),
		.row_end   (row_end),
		.image_end (image_end)
	);

endmodule

>>> sim/gamma_correct_mip_downsample_unit_tb.sv
// Testbench for the gamma-correct 2x2 mip downsampler: random pixel streams checked against a predictor.
`timescale 1ns / 1ps

module gamma_correct_mip_downsample_unit_tb;
	import gcmd_pkg::*;

	localparam int unsigned MAX_W      = 4096;
	localparam int unsigned MAX_H      = 4096;
	localparam int unsigned GAMMA_MIL  = 2200;
	localparam int unsigned PAIR_SLOTS = (MAX_W + 1) / 2;
	localparam int unsigned RANDOM_PIX = 1450;
	localparam int unsigned SETTLE     = 30;   // beyond the pipeline

	// register indexes, byte address is 4*index
	typedef enum logic [0:0] {
		REG_SRC_WIDTH  = 1'b0,
		REG_SRC_HEIGHT = 1'b1
	} reg_idx_e;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        row_end;
		logic        image_end;
		logic [11:0] dest_width;
		logic [11:0] dest_height;
	} mip_px_t;

	// Mip predictor plus store of expected output pixels.
	class mip_scoreboard;
		int unsigned lin [256];
		int unsigned row_pairs [PAIR_SLOTS][4];
		int unsigned left_hold [4];
		int unsigned col, row;
		int unsigned src_w, src_h;
		mip_px_t     pending_q [$];
		int unsigned mismatches;
		int unsigned checked;

		function new();
			build_gamma();
			col = 0; row = 0; src_w = 1; src_h = 1;
			mismatches = 0; checked = 0;
			foreach (left_hold[i]) left_hold[i] = 0;
		endfunction

		// floor square root, bit by bit from the top
		function longint unsigned root_floor(longint unsigned n);
			longint unsigned r, t;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= n) r = t;
			end
			return r;
		endfunction

		// Q30 power: integer part by repeated multiply, fraction by nested roots
		function void build_gamma();
			longint unsigned x, acc;
			int unsigned frac;
			lin[0] = 0;
			for (int v = 1; v < 256; v++) begin
				x    = (longint'(v) << 30) / 255;
				acc  = 64'd1 << 30;
				frac = GAMMA_MIL % 1000;
				for (int k = 0; k < GAMMA_MIL / 1000; k++) acc = (acc * x) >> 30;
				for (int i = 0; i < 24; i++) begin
					x    = root_floor(x << 30);
					frac = frac * 2;
					if (frac >= 1000) begin
						frac = frac - 1000;
						acc  = (acc * x) >> 30;
					end
				end
				lin[v] = int'((acc * 65535 + (64'd1 << 29)) >> 30);
			end
		endfunction

		function logic [7:0] to_code(int unsigned avg);
			int unsigned n;
			n = 0;
			for (int v = 1; v < 256; v++) if (lin[v] <= avg) n++;
			return n[7:0];
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned m);
			if (v == 0) return 1;
			return (v > m) ? m : v;
		endfunction

		function void set_reg(reg_idx_e idx, logic [12:0] val);
			if (idx == REG_SRC_WIDTH) src_w = val;
			else src_h = val;
			col = 0;
			row = 0;
		endfunction

		function void note_pixel(pixel_t p);
			int unsigned w, h, nw, nh, ox, oy;
			int unsigned cur [4], pr [4], tot [4];
			bit xok, yok;
			mip_px_t e;
			w  = clamp(src_w, MAX_W);
			h  = clamp(src_h, MAX_H);
			nw = (w > 1) ? w / 2 : 1;
			nh = (h > 1) ? h / 2 : 1;
			cur[0] = lin[p.red];
			cur[1] = lin[p.green];
			cur[2] = lin[p.blue];
			cur[3] = p.alpha;
			if (!(w == 1 && h == 1) && col < w && row < h) begin
				xok = (w > 1) ? ((col >> 1) < nw) : 1'b1;
				yok = (h > 1) ? ((row >> 1) < nh) : 1'b1;
				if (xok && yok) begin
					ox = (w > 1) ? col >> 1 : 0;
					oy = (h > 1) ? row >> 1 : 0;
					if (w > 1 && col[0] == 1'b0) begin
						left_hold = cur;
					end else begin
						for (int c = 0; c < 4; c++)
							pr[c] = (w > 1) ? left_hold[c] + cur[c] : 2 * cur[c];
						if (h > 1 && row[0] == 1'b0) begin
							for (int c = 0; c < 4; c++) row_pairs[ox % PAIR_SLOTS][c] = pr[c];
						end else begin
							for (int c = 0; c < 4; c++)
								tot[c] = (h > 1) ? pr[c] + row_pairs[ox % PAIR_SLOTS][c]
									: 2 * pr[c];
							e.red         = to_code(tot[0] / 4);
							e.green       = to_code(tot[1] / 4);
							e.blue        = to_code(tot[2] / 4);
							e.alpha       = 8'(tot[3] / 4);
							e.row_end     = (ox == nw - 1);
							e.image_end   = (ox == nw - 1) && (oy == nh - 1);
							e.dest_width  = 12'(nw);
							e.dest_height = 12'(nh);
							pending_q.push_back(e);
						end
					end
				end
			end
			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h) row = 0;
			end
		endfunction

		function void check_result(mip_px_t got);
			mip_px_t want;
			checked++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("%0t: unexpected output beat %p", $realtime, got);
				return;
			end
			want = pending_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: output beat mismatch\n  expected %p\n  actual   %p",
						$realtime, want, got);
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [7:0]  in_red, in_green, in_blue, in_alpha;
	logic        out_valid, out_stall;
	logic [7:0]  out_red, out_green, out_blue, out_alpha;
	logic        row_end, image_end;
	logic [11:0] dest_width, dest_height;

	gamma_correct_mip_downsample_unit #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H),
		.GAMMA_MILLI(GAMMA_MIL)
	) u_top (.*);

	mip_scoreboard mip_sb = new();
	int unsigned   pix_sent;
	int unsigned   phases_run;
	bit            sink_calm;   // stretches without output stalls

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous fixed bound: the slowest legal run is well under a tenth of this.
	initial begin
		#20ms;
		$display("gamma_correct_mip_downsample_unit verification failed");
		$finish;
	end

	// Output side: random stall bursts, mostly short, a few long, some calm stretches.
	int unsigned stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else if (!sink_calm && $urandom_range(0, 99) < 20) begin
				stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
					: $urandom_range(0, 3);
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Output beat monitor, sampled before this edge's updates land.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mip_sb.check_result({out_red, out_green, out_blue, out_alpha,
				row_end, image_end, dest_width, dest_height});
	end

	// APB write: setup cycle, then access cycle; lands at the access edge.
	task automatic reg_write(reg_idx_e idx, logic [12:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {19'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		mip_sb.set_reg(idx, val);
	endtask

	// Idle point between phases: all beats back, then let the pipeline settle.
	task automatic drain_out();
		while (mip_sb.pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_size(logic [12:0] w, logic [12:0] h);
		drain_out();
		reg_write(REG_SRC_WIDTH, w);
		reg_write(REG_SRC_HEIGHT, h);
		phases_run++;
	endtask

	// One pixel beat; gap_bias 0 sends back-to-back.
	task automatic send_pixel(pixel_t p, int unsigned gap_bias);
		int unsigned gap;
		gap = 0;
		if (gap_bias != 0 && $urandom_range(0, 99) < gap_bias)
			gap = ($urandom_range(0, 24) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_red   <= p.red;
		in_green <= p.green;
		in_blue  <= p.blue;
		in_alpha <= p.alpha;
		do @(posedge clk); while (in_stall);
		mip_sb.note_pixel(p);
		pix_sent++;
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		return {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
	endfunction

	task automatic stream(int unsigned n, int unsigned gap_bias);
		for (int i = 0; i < n; i++) send_pixel(rand_pixel(), gap_bias);
		in_valid <= 1'b0;
	endtask

	initial begin
		pixel_t      pat [16];
		int unsigned w, h, n, rand_start, bias;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		in_red    = '0;
		in_green  = '0;
		in_blue   = '0;
		in_alpha  = '0;
		sink_calm = 1'b0;
		pix_sent  = 0;
		phases_run = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size is 1x1: pixels are swallowed, nothing comes out
		stream(3, 0);

		// 4x4 with corner values and alternating bit patterns
		set_size(13'd4, 13'd4);
		pat = '{32'h00000000, 32'hFFFFFFFF, 32'h00FF00FF, 32'hFF00FF00,
		        32'hAA55AA55, 32'h55AA55AA, 32'h01020304, 32'hFEFDFCFB,
		        32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
		        32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80808080, 32'h7F7F7F7F};
		foreach (pat[i]) send_pixel(pat[i], 0);
		in_valid <= 1'b0;
		// single column, single row, odd both ways, zero acting as one
		set_size(13'd1, 13'd4); stream(4, 0);
		set_size(13'd4, 13'd1); stream(4, 0);
		set_size(13'd3, 13'd3); stream(9, 0);
		set_size(13'd0, 13'd0); stream(2, 0);

		// random sizes, mostly whole images, some cut short, with pauses
		rand_start = pix_sent;
		while (pix_sent - rand_start < RANDOM_PIX) begin
			case ($urandom_range(0, 9))
				0:       w = 1;
				1:       w = 0;
				default: w = $urandom_range(2, 13);
			endcase
			case ($urandom_range(0, 9))
				0:       h = 1;
				1:       h = 0;
				default: h = $urandom_range(2, 9);
			endcase
			set_size(13'(w), 13'(h));
			sink_calm = ($urandom_range(0, 4) == 0);
			bias = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
			n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(1, 3);
			if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
			if ($urandom_range(0, 3) == 0) begin
				// hold the source back until every beat so far is out
				stream(n / 2, bias);
				while (mip_sb.pending_q.size() != 0) @(posedge clk);
				stream(n - n / 2, bias);
			end else begin
				stream(n, bias);
			end
		end
		sink_calm = 1'b0;

		// widest and tallest settings, clamped from the 13-bit register maximum;
		// a single row or column gives beats right away, so a short stream shows the clamp
		set_size(13'h1FFF, 13'd1); stream(64, 10);
		set_size(13'd1, 13'h1FFF); stream(64, 10);
		set_size(13'd4096, 13'd4096); stream(2, 0);

		drain_out();
		$display("covered %0d source pixels over %0d size settings, %0d mip beats checked",
			pix_sent, phases_run, mip_sb.checked);
		$display("sizes: 1x1, single row/column, odd, zero, random up to 13x9, 4096 clamp");
		if (mip_sb.mismatches == 0 && mip_sb.pending_q.size() == 0) begin
			$display("gamma_correct_mip_downsample_unit verification clean");
		end else begin
			$display("%0d mismatches, %0d beats missing", mip_sb.mismatches,
				mip_sb.pending_q.size());
			$display("gamma_correct_mip_downsample_unit verification failed");
		end
		$finish;
	end

endmodule
